// ===== rtl/core/gavg_pkg.sv =====
// shared types and constants for the four-neighbour grid average block
// no dependencies
`default_nettype none

package gavg_pkg;

  localparam int MAX_COLS = 1024;
  localparam int DATA_W   = 32;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROW_W    = 16;
  localparam int SUM_W    = DATA_W + 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROW_W-1:0]  ROWS_RESET = ROW_W'(102);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(102);
  localparam logic [ROW_W-1:0]  ROWS_MIN   = ROW_W'(3);
  localparam logic [COLS_W-1:0] COLS_MIN   = COLS_W'(3);
  localparam logic [COLS_W-1:0] COLS_MAX   = COLS_W'(MAX_COLS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = CFG_IDX_W'(0),
    REG_GRID_COLS = CFG_IDX_W'(1)
  } cfg_reg_t;

  // one line buffer entry: newest row and the row before it, same column
  typedef struct packed {
    logic signed [DATA_W-1:0] prev;
    logic signed [DATA_W-1:0] older;
  } line_entry_t;

  // one result word
  typedef struct packed {
    logic signed [DATA_W-1:0] average;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/gavg_line_ram.sv =====
// dual line buffer memory, one write and one read port, registered read
// depends on gavg_pkg
`default_nettype none

module gavg_line_ram
  import gavg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [COL_W-1:0] waddr,
  input  wire line_entry_t wdata,
  input  wire logic [COL_W-1:0] raddr,
  output line_entry_t      rdata
);

  line_entry_t mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gavg_out_buf.sv =====
// result output register with one skid word behind it
// depends on gavg_pkg
`default_nettype none

module gavg_out_buf
  import gavg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t din,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      dout,
  output logic         full
);

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    drain;

  assign drain = main_v_r && !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (drain) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || drain) begin
        main_nxt   = din;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = din;
        skid_v_nxt = 1'b1;
      end
    end else if (drain) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign dout      = main_r;
  assign full      = skid_v_r;

endmodule

`default_nettype wire

// ===== rtl/core/four_neighbour_grid_average.sv =====
// top level of the four-neighbour grid average (4-point stencil) block
// depends on gavg_pkg, gavg_line_ram and gavg_out_buf
//
// usage
//   samples of a grid arrive on the in_ channel in row-major raster order, one
//   word per accepted edge (in_valid high, in_stall low). for every interior
//   point (r-1, j) the block emits (up + down + left + right) / 4, rounded
//   toward zero, when the sample at (r, j) is taken; border points give no
//   word. out_row/out_col carry the point, out_last marks the final interior
//   point of the grid, after which the counters wrap to a new grid.
//   throughput is one sample per clock while in_stall is low: each accepted
//   sample costs one write and one read of the single line buffer memory, which
//   holds both stored rows side by side so one port pair serves every column.
//   a result word is registered into the output stage on the edge that took its
//   sample, into the skid word if the output register is still held.
//   stalls: the output register has one skid word behind it, so a sample is
//   still taken while a result waits; only when the skid word is also full
//   does in_stall rise, and it falls as soon as the receiver drains a word.
//   reset sets grid_rows and grid_cols to 102 and clears the counters and the
//   output stage; the line buffer is not cleared, the first two rows of each
//   grid fill it. a write on cfg_ (index 0 grid_rows, 1 grid_cols, cfg_ready
//   always high) also restarts the grid at row 0, column 0.
`default_nettype none

module four_neighbour_grid_average
  import gavg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // sample input
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] in_sample,
  // result output
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_average,
  output logic [ROW_W-1:0]              out_row,
  output logic [COL_W-1:0]              out_col,
  output logic                          out_last,
  // register writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [ROW_W-1:0]  grid_rows_r, grid_rows_nxt;
  logic [COLS_W-1:0] grid_cols_r, grid_cols_nxt;
  logic [ROW_W-1:0]  rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic              cfg_we;
  logic              cfg_hit;

  // raster position
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COLS_W-1:0] col_inc1;
  logic [COLS_W-1:0] col_inc2;
  logic [COLS_W-1:0] addr_ahead1;
  logic [COLS_W-1:0] addr_ahead2;
  logic              row_end;
  logic [ROW_W:0]    row_inc;

  // neighbour window: cur_r is the entry of this column, ram_q the next one
  line_entry_t       cur_r;
  logic signed [DATA_W-1:0] left_r;
  line_entry_t       ram_q;
  line_entry_t       ram_wdata;
  logic [COL_W-1:0]  ram_raddr;

  logic              in_accept;
  logic              interior;
  logic signed [SUM_W-1:0] nb_sum;
  logic signed [SUM_W-1:0] nb_adj;
  result_t           res;
  result_t           out_word;
  logic              buf_full;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    grid_rows_nxt = grid_rows_r;
    grid_cols_nxt = grid_cols_r;
    cfg_hit       = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_ROWS: begin
          grid_rows_nxt = cfg_wdata[ROW_W-1:0];
          cfg_hit       = 1'b1;
        end
        REG_GRID_COLS: begin
          grid_cols_nxt = cfg_wdata[COLS_W-1:0];
          cfg_hit       = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // out-of-range sizes are clamped
  always_comb begin
    rows_eff = (grid_rows_r < ROWS_MIN) ? ROWS_MIN : grid_rows_r;
    if (grid_cols_r < COLS_MIN) begin
      cols_eff = COLS_MIN;
    end else if (grid_cols_r > COLS_MAX) begin
      cols_eff = COLS_MAX;
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  // ---------------------------------------------------------------------
  // raster counters
  // ---------------------------------------------------------------------
  assign in_accept = in_valid && !in_stall;

  assign col_inc1 = {1'b0, col_r} + COLS_W'(1);
  assign col_inc2 = {1'b0, col_r} + COLS_W'(2);
  assign row_end  = (col_inc1 == cols_eff);
  assign row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);

  // column one and two ahead, wrapped at the row length (cols is at least 3)
  assign addr_ahead1 = (col_inc1 >= cols_eff) ? col_inc1 - cols_eff : col_inc1;
  assign addr_ahead2 = (col_inc2 >= cols_eff) ? col_inc2 - cols_eff : col_inc2;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_hit) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
      row_r       <= '0;
      col_r       <= '0;
    end else begin
      grid_rows_r <= grid_rows_nxt;
      grid_cols_r <= grid_cols_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // line buffer: read the entry one column ahead of the next sample
  // ---------------------------------------------------------------------
  always_comb begin
    if (!rst_n || cfg_hit) begin
      // next sample is column 0, so column 1 must be on the read port
      ram_raddr = COL_W'(1);
    end else if (in_accept) begin
      ram_raddr = addr_ahead2[COL_W-1:0];
    end else begin
      ram_raddr = addr_ahead1[COL_W-1:0];
    end
  end

  // the current row moves down into the older slot as the sample lands
  assign ram_wdata.prev  = in_sample;
  assign ram_wdata.older = cur_r.prev;

  gavg_line_ram u_line_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r  <= ram_q;
      left_r <= cur_r.prev;
    end
  end

  // ---------------------------------------------------------------------
  // stencil: up, left, right and the new sample below
  // ---------------------------------------------------------------------
  assign interior = (row_r >= ROW_W'(2)) && (col_r != '0) && (col_inc2 <= cols_eff);

  assign nb_sum = SUM_W'(cur_r.older) + SUM_W'(left_r)
                + SUM_W'(ram_q.prev) + SUM_W'(in_sample);
  // round toward zero: bias negative sums by three before the shift
  assign nb_adj = nb_sum + (nb_sum[SUM_W-1] ? SUM_W'(3) : SUM_W'(0));

  assign res.average = nb_adj[SUM_W-1:2];
  assign res.row     = row_r - ROW_W'(1);
  assign res.col     = col_r;
  assign res.last    = (row_inc == {1'b0, rows_eff}) && (col_inc2 == cols_eff);

  gavg_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && interior),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (out_word),
    .full      (buf_full)
  );

  assign in_stall    = buf_full;
  assign out_average = out_word.average;
  assign out_row     = out_word.row;
  assign out_col     = out_word.col;
  assign out_last    = out_word.last;

`ifndef ASSERT_OFF
  // column position never runs past the row length
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < cols_eff)
    else $error("column counter beyond row length");

  // a register write restarts the grid
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0) && (row_r == '0))
    else $error("register write did not restart the grid");

  // last column of a row wraps to column 0
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && row_end && !cfg_hit |=> (col_r == '0))
    else $error("column did not wrap at row end");

  // input only held off while a result word is waiting
  a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // a flagged last word sits in the final interior column
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && interior && res.last |-> (col_inc2 == cols_eff) && row_end == 1'b0)
    else $error("last flag away from final interior column");
`endif

endmodule

`default_nettype wire
